@@ sv/adp_pkg.sv @@
package adp_pkg;

  // sizing of the pattern group
  localparam int unsigned PATTERN_LEN = 32;
  localparam int unsigned MAX_EDITS   = 3;
  localparam int unsigned GROUP_SIZE  = 4;
  localparam int unsigned NUM_ROWS    = MAX_EDITS + 1;

  // base codes and field widths
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned MATCH_W    = 4;
  localparam int unsigned PATTERN_W  = 64;

  // configuration register file
  localparam int unsigned NUM_REGS   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned REG_IDX_W  = $clog2(NUM_REGS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LAST = CFG_IDX_W'(NUM_REGS - 1);

  typedef logic [PATTERN_LEN-1:0]              row_t;
  typedef row_t [NUM_ROWS-1:0]                 cells_t;
  typedef logic [PATTERN_W-1:0]                pattern_t;
  typedef pattern_t [NUM_REGS-1:0]             pattern_arr_t;
  typedef cells_t [GROUP_SIZE-1:0]             group_cells_t;
  typedef logic [MASK_W-1:0]                   mask_t;
  typedef logic [MATCH_W-1:0]                  match_t;

endpackage

@@ sv/adp_cfg_regs.sv @@
module adp_cfg_regs
  import adp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  pattern_t             cfg_wdata_i,
  output pattern_arr_t         patterns_o
);

  pattern_arr_t pattern_q;

  // pattern registers, writes beyond the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
    end else if (cfg_we_i && cfg_index_i <= REG_PATTERN_LAST) begin
      pattern_q[cfg_index_i[REG_IDX_W-1:0]] <= cfg_wdata_i;
    end
  end

  assign patterns_o = pattern_q;

endmodule

@@ sv/adp_cell_update.sv @@
module adp_cell_update
  import adp_pkg::*;
(
  input  pattern_t pattern_i,
  input  mask_t    class_mask_i,
  input  cells_t   prev_i,
  output cells_t   cur_o,
  output match_t   match_o
);

  row_t   hit;
  cells_t cur;
  match_t res;

  // per-position base hit against the text class mask
  always_comb begin
    for (int unsigned i = 0; i < PATTERN_LEN; i++) begin
      hit[i] = class_mask_i[pattern_i[CODE_W*i +: CODE_W]];
    end
  end

  // edit-distance cells: exact row, then one row per extra edit
  always_comb begin
    cur = '0;
    cur[0][0] = hit[0];
    for (int unsigned i = 1; i < PATTERN_LEN; i++) begin
      cur[0][i] = prev_i[0][i-1] & hit[i];
    end
    for (int unsigned j = 1; j < NUM_ROWS; j++) begin
      cur[j][0] = 1'b1;
      for (int unsigned i = 1; i < PATTERN_LEN; i++) begin
        cur[j][i] = (prev_i[j][i-1] & hit[i])
                  | (prev_i[j-1][i-1] & ~hit[i])
                  | prev_i[j-1][i]
                  | cur[j-1][i-1];
      end
    end
  end

  // pattern end with exactly j edits
  always_comb begin
    res = '0;
    res[0] = cur[0][PATTERN_LEN-1];
    for (int unsigned j = 1; j < NUM_ROWS; j++) begin
      res[j] = cur[j][PATTERN_LEN-1] & ~cur[j-1][PATTERN_LEN-1];
    end
  end

  assign cur_o   = cur;
  assign match_o = res;

endmodule

@@ sv/approx_dna_pattern_matcher.sv @@
// Approximate DNA matcher: each request carries one text position as a class
// mask over the base codes A=0, C=1, T=2, G=3, and returns one 4-bit result
// whose bit j says that some pattern of the group ends at this position with
// exactly j edits. A request is taken every cycle while results are not held
// back; its result passes the input register, then the result register, and
// the update of the stored edit cells of all four patterns sets this rate.
// Patterns are written through the config port (index 0..3, 2-bit base codes,
// position 0 in the low bits); the user must do so only while no request is in
// flight; the block does not enforce this. Reset clears patterns and stored cells.
module approx_dna_pattern_matcher
  import adp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [MASK_W-1:0]    class_mask_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [MATCH_W-1:0]   match_by_distance_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PATTERN_W-1:0] cfg_wdata_i
);

  pattern_arr_t patterns;
  group_cells_t prev_cells_q;
  group_cells_t cur_cells;
  match_t [GROUP_SIZE-1:0] pat_match;
  match_t       match_d;
  match_t       match_q;
  mask_t        mask_q;
  logic         s1_valid_q;
  logic         out_valid_q;
  logic         s1_go;
  logic         s1_fire;

  // configuration storage
  adp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .patterns_o  (patterns)
  );

  // pipeline flow control
  assign s1_go      = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_ready_o = !s1_valid_q || s1_go;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mask_q <= class_mask_i;
    end
  end

  // one cell update per pattern
  for (genvar g = 0; g < GROUP_SIZE; g++) begin : g_pat
    adp_cell_update u_upd (
      .pattern_i    (patterns[g]),
      .class_mask_i (mask_q),
      .prev_i       (prev_cells_q[g]),
      .cur_o        (cur_cells[g]),
      .match_o      (pat_match[g])
    );
  end

  // merge results of the group
  always_comb begin
    match_d = '0;
    for (int unsigned g = 0; g < GROUP_SIZE; g++) begin
      match_d = match_d | pat_match[g];
    end
  end

  // cell state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cells_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s1_fire) begin
        prev_cells_q <= cur_cells;
      end
      if (s1_go) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      match_q <= match_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign match_by_distance_o = match_q;

  // a result only shows up after a request sat in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a request in the input register");

  // cell state moves only when a request is consumed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(prev_cells_q))
    else $error("cell state changed without a request");

  // empty input register always takes a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled while input register empty");

  // a waiting result keeps the input register full request held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> s1_valid_q && $stable(mask_q))
    else $error("stalled request lost from input register");

endmodule

@@ sim/tb_approx_dna_pattern_matcher.sv @@
`timescale 1ns / 1ps

module tb_approx_dna_pattern_matcher;
  import adp_pkg::*;

  // clock, reset and block ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  mask_t                class_mask_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  match_t               match_by_distance_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  pattern_t             cfg_wdata_i = '0;

  // pending text positions, expected results, and the predictor's own state
  mask_t       text_q [$];
  match_t      expected_match_q [$];
  pattern_t    pattern_model [NUM_REGS];
  row_t        cell_model [GROUP_SIZE][NUM_ROWS];
  int unsigned err_cnt = 0;
  bit          no_stall = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;

  approx_dna_pattern_matcher u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .class_mask_i        (class_mask_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .match_by_distance_o (match_by_distance_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // edit-distance cell update for one text position, ORed over the group
  function automatic match_t predict_match(input mask_t mask);
    row_t              cur [NUM_ROWS];
    row_t              old [NUM_ROWS];
    logic [CODE_W-1:0] code;
    logic              hit;
    match_t            acc;
    acc = '0;
    for (int g = 0; g < GROUP_SIZE; g++) begin
      for (int j = 0; j < NUM_ROWS; j++) begin
        old[j] = cell_model[g][j];
        cur[j] = '0;
      end
      code = pattern_model[g][CODE_W-1:0];
      cur[0][0] = mask[code];
      for (int j = 1; j <= MAX_EDITS; j++) cur[j][0] = 1'b1;
      for (int i = 1; i < PATTERN_LEN; i++) begin
        code = pattern_model[g][CODE_W*i +: CODE_W];
        hit = mask[code];
        cur[0][i] = old[0][i-1] & hit;
        for (int j = 1; j <= MAX_EDITS; j++) begin
          cur[j][i] = (old[j][i-1] & hit) | (old[j-1][i-1] & ~hit)
                    | old[j-1][i] | cur[j-1][i-1];
        end
      end
      acc[0] = acc[0] | cur[0][PATTERN_LEN-1];
      for (int j = 1; j <= MAX_EDITS; j++) begin
        acc[j] = acc[j] | (cur[j][PATTERN_LEN-1] & ~cur[j-1][PATTERN_LEN-1]);
      end
      for (int j = 0; j < NUM_ROWS; j++) cell_model[g][j] = cur[j];
    end
    return acc;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_stall) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_match_q.push_back(predict_match(class_mask_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (text_q.size() > 0) begin
          class_mask_i <= text_q.pop_front();
          in_valid_i <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_match_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result match_by_distance=%h", match_by_distance_o);
        end else begin
          match_t want;
          want = expected_match_q.pop_front();
          if (want !== match_by_distance_o) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch match_by_distance: expected %h actual %h",
                       want, match_by_distance_o);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall = pick_gap();
      end
    end
  end

  // register write, mirrored into the predictor
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input pattern_t data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    if (idx <= REG_PATTERN_LAST) pattern_model[idx - REG_PATTERN_0] = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block until every request has been sent and answered, plus pipeline drain
  task automatic wait_idle();
    while (text_q.size() != 0 || in_valid_i || expected_match_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // text made of pattern copies with a few edits, mixed with noise
  task automatic build_text(input int unsigned n_items);
    logic [CODE_W-1:0] seq [$];
    int unsigned       start;
    int unsigned       g;
    int unsigned       edits;
    int unsigned       pos;
    mask_t             m;
    start = text_q.size();
    while (text_q.size() - start < n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        g = $urandom_range(0, GROUP_SIZE - 1);
        seq.delete();
        for (int i = 0; i < PATTERN_LEN; i++)
          seq.push_back(pattern_model[g][CODE_W*i +: CODE_W]);
        edits = $urandom_range(0, MAX_EDITS + 1);
        for (int e = 0; e < edits; e++) begin
          pos = $urandom_range(0, seq.size() - 1);
          case ($urandom_range(0, 2))
            0: seq[pos] = seq[pos] ^ CODE_W'($urandom_range(1, 3));
            1: seq.insert(pos, CODE_W'($urandom_range(0, 3)));
            default: seq.delete(pos);
          endcase
        end
        foreach (seq[k]) begin
          m = mask_t'(1) << seq[k];
          // occasionally an ambiguous base
          if ($urandom_range(0, 7) == 0) m = m | mask_t'($urandom_range(0, 15));
          text_q.push_back(m);
        end
      end else begin
        repeat ($urandom_range(1, 6)) text_q.push_back(mask_t'($urandom_range(0, 15)));
      end
    end
  endtask

  // stimulus sequence
  initial begin
    pattern_t p_val [NUM_REGS];
    for (int g = 0; g < NUM_REGS; g++) pattern_model[g] = '0;
    for (int g = 0; g < GROUP_SIZE; g++)
      for (int j = 0; j < NUM_ROWS; j++) cell_model[g][j] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: first positions after reset with all-zero patterns,
    // empty mask, full mask, each single base, mixed masks
    text_q.push_back(mask_t'(4'h0));
    text_q.push_back(mask_t'(4'hF));
    for (int c = 0; c < MASK_W; c++) text_q.push_back(mask_t'(1) << c);
    text_q.push_back(mask_t'(4'h3));
    text_q.push_back(mask_t'(4'hC));
    text_q.push_back(mask_t'(4'h5));
    text_q.push_back(mask_t'(4'hA));
    repeat (6) text_q.push_back(mask_t'(4'h1));
    text_q.push_back(mask_t'(4'h0));
    text_q.push_back(mask_t'(4'hE));
    wait_idle();

    // extreme patterns, plus writes to indexes past the register file
    cfg_write(REG_PATTERN_0 + CFG_IDX_W'(0), '1);
    cfg_write(REG_PATTERN_0 + CFG_IDX_W'(1), '0);
    cfg_write(REG_PATTERN_0 + CFG_IDX_W'(2), {(PATTERN_W/4){4'h5}});
    cfg_write(REG_PATTERN_0 + CFG_IDX_W'(3), {(PATTERN_W/4){4'hA}});
    cfg_write(CFG_IDX_W'(REG_PATTERN_LAST + 1), '1);
    cfg_write({CFG_IDX_W{1'b1}}, {(PATTERN_W/4){4'h3}});

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        for (int g = 0; g < NUM_REGS; g++) begin
          if (ph == 4) p_val[g] = (g % 2 == 0) ? '0 : '1;
          else p_val[g] = {$urandom, $urandom};
          cfg_write(REG_PATTERN_0 + CFG_IDX_W'(g), p_val[g]);
        end
      end
      no_stall = (ph == 2);
      build_text(80);
      wait_idle();
    end

    if (err_cnt == 0 && expected_match_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
